/* hw/rtl/vector_slide_unit_assert.svh */
// ----------------------------------------------------------------------------
// Vector slide unit assertion macros
// Shared concurrent assertion forms, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VECTOR_SLIDE_UNIT_ASSERT_SVH
`define VECTOR_SLIDE_UNIT_ASSERT_SVH

// same-cycle implication
`define VSU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/vsu_pkg.sv */
// ----------------------------------------------------------------------------
// Vector slide unit package
// Word types, register indexes, slide modes and defaults.
// ----------------------------------------------------------------------------
package vsu_pkg;

    localparam int ELEM_W           = 64;
    localparam int HALF_W           = 32;
    localparam int LEN_W            = 9;
    localparam int CFG_IDX_W        = 3;
    localparam int MAX_ELEMENTS_DEF = 256;

    localparam logic [CFG_IDX_W-1:0] REG_ELEM_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLIDE_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_USE_MASK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLIDE_AMT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALAR      = 3'd5;

    localparam logic [1:0] MODE_UP    = 2'd0;
    localparam logic [1:0] MODE_UP1   = 2'd1;
    localparam logic [1:0] MODE_DOWN  = 2'd2;
    localparam logic [1:0] MODE_DOWN1 = 2'd3;

    localparam logic             EW_64       = 1'b1;
    localparam logic [LEN_W-1:0] VL_RESET    = 9'd1;

    typedef struct packed {
        logic [ELEM_W-1:0] source_elem;
        logic              mask_bit;
        logic [ELEM_W-1:0] old_dest;
    } t_in_word;

    typedef struct packed {
        logic [ELEM_W-1:0] dest_elem;
        logic              last;
    } t_out_word;

endpackage

/* hw/rtl/vsu_store.sv */
// ----------------------------------------------------------------------------
// Vector slide unit source store
// One-write, one-read synchronous memory of source elements, read data
// registered and held between reads.
// ----------------------------------------------------------------------------
`include "vector_slide_unit_assert.svh"

module vsu_store #(
    parameter int Depth = vsu_pkg::MAX_ELEMENTS_DEF,
    parameter int DataW = vsu_pkg::ELEM_W
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [DataW-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [DataW-1:0]         o_rdata
);

    localparam int AddrW = $clog2(Depth);

    logic [DataW-1:0] mem [Depth];
    logic [DataW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

    `VSU_ASSERT_NOW(a_no_collide, i_we && i_re, i_waddr != i_raddr, "read and write hit one entry")
    `VSU_ASSERT_NOW(a_waddr_range, i_we, i_waddr <= AddrW'(Depth - 1), "write address past depth")

endmodule

/* hw/rtl/vector_slide_unit.sv */
// ----------------------------------------------------------------------------
// Vector slide unit
// Streams vector elements, stores each source element by position and
// produces the slid destination element with a last flag.
//
//   channel  direction  handshake                  word
//   in       input      i_in_valid / o_in_ready    vsu_pkg::t_in_word
//   out      output     o_out_valid / i_out_ready  vsu_pkg::t_out_word
//   cfg      input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One word per cycle sustained while the output is not stalled.
// The store is written and read in the accept cycle; the registered read
// feeds the second stage, then the output register.
// Synchronous active-low reset clears the element counter and valid flags
// and loads the configuration defaults; the store needs no clearing pass.
// A stalled output holds both stages; input stays open while a stage is free.
// ----------------------------------------------------------------------------
`include "vector_slide_unit_assert.svh"

module vector_slide_unit #(
    parameter int MaxElements = vsu_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  vsu_pkg::t_in_word                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output vsu_pkg::t_out_word               o_out_data,
    input  logic                             i_cfg_we,
    input  logic [vsu_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [vsu_pkg::ELEM_W-1:0]       i_cfg_data
);

    localparam int IdxW = $clog2(MaxElements);
    localparam int CntW = IdxW + 1;
    localparam int CmpW = ((CntW > vsu_pkg::LEN_W) ? CntW : vsu_pkg::LEN_W) + 1;

    typedef enum logic [2:0] {
        SEL_OLD,
        SEL_SRC,
        SEL_STORE,
        SEL_SCALAR,
        SEL_ZERO
    } t_sel;

    // configuration
    logic                          r_ew;
    logic [1:0]                    r_mode;
    logic                          r_use_mask;
    logic [vsu_pkg::LEN_W-1:0]     r_amount;
    logic [vsu_pkg::LEN_W-1:0]     r_vl;
    logic [vsu_pkg::ELEM_W-1:0]    r_scalar;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ew       <= vsu_pkg::EW_64;
            r_mode     <= vsu_pkg::MODE_UP;
            r_use_mask <= 1'b0;
            r_amount   <= '0;
            r_vl       <= vsu_pkg::VL_RESET;
            r_scalar   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vsu_pkg::REG_ELEM_WIDTH: r_ew       <= i_cfg_data[0];
                vsu_pkg::REG_SLIDE_MODE: r_mode     <= i_cfg_data[1:0];
                vsu_pkg::REG_USE_MASK:   r_use_mask <= i_cfg_data[0];
                vsu_pkg::REG_SLIDE_AMT:  r_amount   <= i_cfg_data[vsu_pkg::LEN_W-1:0];
                vsu_pkg::REG_VECTOR_LEN: r_vl       <= i_cfg_data[vsu_pkg::LEN_W-1:0];
                vsu_pkg::REG_SCALAR:     r_scalar   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 0: index, decision, store access
    logic [IdxW-1:0]           r_index;
    logic [IdxW-1:0]           n_index;
    logic [CmpW-1:0]           k_ext;
    logic [CmpW-1:0]           amt_ext;
    logic [CmpW-1:0]           vl_ext;
    logic [CmpW-1:0]           rd_off;
    logic                      last;
    logic                      wrap;
    logic                      active;
    t_sel                      sel;
    logic                      in_acc;
    logic                      out_adv;
    logic                      s1_free;
    logic                      rd_en;
    logic [vsu_pkg::ELEM_W-1:0] rd_data;
    logic                      r_s1_valid;

    assign k_ext   = CmpW'(r_index);
    assign amt_ext = CmpW'(r_amount);
    assign vl_ext  = CmpW'(r_vl);
    assign rd_off  = k_ext - amt_ext;
    assign last    = (k_ext + CmpW'(1)) == vl_ext;
    assign wrap    = r_index == IdxW'(MaxElements - 1);
    assign active  = !r_use_mask || i_in_data.mask_bit;

    always_comb begin
        sel = SEL_OLD;
        if (r_mode == vsu_pkg::MODE_UP || r_mode == vsu_pkg::MODE_UP1) begin
            if (r_mode == vsu_pkg::MODE_UP1 && r_index == '0) begin
                sel = SEL_SCALAR;
            end else if (k_ext >= amt_ext && active) begin
                // zero amount reads the entry being written: take the source
                sel = (r_amount == '0) ? SEL_SRC : SEL_STORE;
            end
        end else begin
            if (r_mode == vsu_pkg::MODE_DOWN1 && last) begin
                sel = SEL_SCALAR;
            end else if (k_ext + amt_ext >= vl_ext) begin
                sel = SEL_ZERO;
            end else if (active) begin
                sel = SEL_SRC;
            end
        end
    end

    assign out_adv    = !o_out_valid || i_out_ready;
    assign s1_free    = !r_s1_valid || out_adv;
    assign o_in_ready = s1_free;
    assign in_acc     = i_in_valid && s1_free;
    assign rd_en      = in_acc && (sel == SEL_STORE);
    assign n_index    = (last || wrap) ? '0 : IdxW'(r_index + 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
        end else if (in_acc) begin
            r_index <= n_index;
        end
    end

    vsu_store #(
        .Depth (MaxElements),
        .DataW (vsu_pkg::ELEM_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (in_acc),
        .i_waddr (r_index),
        .i_wdata (i_in_data.source_elem),
        .i_re    (rd_en),
        .i_raddr (rd_off[IdxW-1:0]),
        .o_rdata (rd_data)
    );

    // stage 1: select result
    logic                       n_s1_valid;
    t_sel                       r_s1_sel;
    logic [vsu_pkg::ELEM_W-1:0] r_s1_src;
    logic [vsu_pkg::ELEM_W-1:0] r_s1_old;
    logic                       r_s1_last;
    logic [vsu_pkg::ELEM_W-1:0] s1_res;
    logic [vsu_pkg::ELEM_W-1:0] s1_fit;

    assign n_s1_valid = in_acc || (r_s1_valid && !out_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_sel  <= sel;
            r_s1_src  <= i_in_data.source_elem;
            r_s1_old  <= i_in_data.old_dest;
            r_s1_last <= last;
        end
    end

    always_comb begin
        case (r_s1_sel)
            SEL_SRC:    s1_res = r_s1_src;
            SEL_STORE:  s1_res = rd_data;
            SEL_SCALAR: s1_res = r_scalar;
            SEL_ZERO:   s1_res = '0;
            default:    s1_res = r_s1_old;
        endcase
    end

    assign s1_fit = r_ew ? s1_res
                         : {{(vsu_pkg::ELEM_W - vsu_pkg::HALF_W){1'b0}},
                            s1_res[vsu_pkg::HALF_W-1:0]};

    // output register
    logic               r_out_valid;
    vsu_pkg::t_out_word r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s1_valid) begin
            r_out.dest_elem <= s1_fit;
            r_out.last      <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `VSU_ASSERT_NOW(a_index_range, 1'b1, r_index <= IdxW'(MaxElements - 1), "index out of range")
    `VSU_ASSERT_NEXT(a_index_clear, in_acc && last, r_index == '0, "index not cleared after last")
    `VSU_ASSERT_NEXT(a_s1_hold, r_s1_valid && !out_adv, r_s1_valid && $stable(r_s1_sel), "s1 lost")
    `VSU_ASSERT_NOW(a_full_stall, r_s1_valid && !out_adv, !o_in_ready, "input open while full")

endmodule

/* dv/vector_slide_unit_tb.sv */
// ----------------------------------------------------------------------------
// Vector slide unit testbench
// Streams element words through the slide unit under a series of slide
// settings: 32/64-bit elements, all four slide modes, masked and unmasked,
// slide amounts and vector lengths from the minimum to the maximum. A
// behavioral predictor tracks the element counter and the source store,
// and every output word is checked against it in order. Both handshakes
// idle at random.
// ----------------------------------------------------------------------------
module vector_slide_unit_tb;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TOTAL_WORDS  = 1850;
    localparam int REPORT_LIMIT = 200;

    localparam logic [vsu_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [vsu_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          in_valid   = 1'b0;
    logic                          in_ready;
    vsu_pkg::t_in_word             in_data    = '0;
    logic                          out_valid;
    logic                          out_ready  = 1'b0;
    vsu_pkg::t_out_word            out_data;
    logic                          cfg_we     = 1'b0;
    logic [vsu_pkg::CFG_IDX_W-1:0] cfg_idx    = '0;
    logic [vsu_pkg::ELEM_W-1:0]    cfg_data   = '0;

    // predictor state
    logic                       cfg_ew     = vsu_pkg::EW_64;
    logic [1:0]                 cfg_mode   = vsu_pkg::MODE_UP;
    logic                       cfg_mask   = 1'b0;
    logic [vsu_pkg::LEN_W-1:0]  cfg_amt    = '0;
    logic [vsu_pkg::LEN_W-1:0]  cfg_vlen   = vsu_pkg::VL_RESET;
    logic [vsu_pkg::ELEM_W-1:0] cfg_scalar = '0;
    int unsigned                elem_idx   = 0;
    logic [vsu_pkg::ELEM_W-1:0] src_store [vsu_pkg::MAX_ELEMENTS_DEF];

    vsu_pkg::t_in_word  elem_pending_q [$];
    vsu_pkg::t_out_word dest_expect_q [$];

    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int in_gap       = 0;
    int out_stall    = 0;
    int words_queued = 0;
    int words_in     = 0;
    int words_out    = 0;
    int vector_ends  = 0;
    int narrow_words = 0;
    int setups       = 0;
    int err_cnt      = 0;
    int cycle_cnt    = 0;
    int mode_words [4] = '{0, 0, 0, 0};

    vector_slide_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic vsu_pkg::t_out_word slide_element(vsu_pkg::t_in_word w);
        int unsigned                k;
        int unsigned                amt;
        int unsigned                vlen;
        logic                       act;
        logic                       fin;
        logic [vsu_pkg::ELEM_W-1:0] res;
        vsu_pkg::t_out_word         o;
        k    = elem_idx;
        amt  = cfg_amt;
        vlen = cfg_vlen;
        act  = !cfg_mask || w.mask_bit;
        fin  = (k + 1) == vlen;
        src_store[k] = w.source_elem;
        if (cfg_mode == vsu_pkg::MODE_UP || cfg_mode == vsu_pkg::MODE_UP1) begin
            if (cfg_mode == vsu_pkg::MODE_UP1 && k == 0)
                res = cfg_scalar;
            else if (k >= amt)
                res = act ? src_store[k - amt] : w.old_dest;
            else
                res = w.old_dest;
        end else begin
            if (cfg_mode == vsu_pkg::MODE_DOWN1 && fin)
                res = cfg_scalar;
            else if (k + amt >= vlen)
                res = '0;
            else
                res = act ? w.source_elem : w.old_dest;
        end
        elem_idx = (fin || (k + 1) >= vsu_pkg::MAX_ELEMENTS_DEF) ? 0 : k + 1;
        if (cfg_ew != vsu_pkg::EW_64) begin
            res[vsu_pkg::ELEM_W-1:vsu_pkg::HALF_W] = '0;
            narrow_words++;
        end
        if (fin)
            vector_ends++;
        mode_words[cfg_mode]++;
        o.dest_elem = res;
        o.last      = fin;
        return o;
    endfunction

    function automatic int pick_gap(int idle_pct);
        int r;
        if ($urandom_range(99) >= idle_pct)
            return 0;
        r = $urandom_range(99);
        if (r < 75)
            return $urandom_range(3, 1);
        if (r < 95)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [vsu_pkg::ELEM_W-1:0] rand_value();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic void queue_word(logic [vsu_pkg::ELEM_W-1:0] src, logic m,
                                       logic [vsu_pkg::ELEM_W-1:0] old);
        vsu_pkg::t_in_word w;
        w.source_elem = src;
        w.mask_bit    = m;
        w.old_dest    = old;
        elem_pending_q = {elem_pending_q, w};
        words_queued++;
    endfunction

    function automatic void queue_rand_words(int count);
        for (int i = 0; i < count; i++)
            queue_word(rand_value(), 1'($urandom_range(1)), rand_value());
    endfunction

    function automatic void note_mismatch(string what, logic [vsu_pkg::ELEM_W-1:0] exp_v,
                                          logic [vsu_pkg::ELEM_W-1:0] act_v);
        err_cnt++;
        if (err_cnt <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
    endfunction

    // driver
    always @(posedge i_clk) begin
        logic fire;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            fire = in_valid && in_ready;
            if (fire) begin
                dest_expect_q = {dest_expect_q, slide_element(in_data)};
                words_in++;
            end
            if (!in_valid || fire) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (elem_pending_q.size() != 0) begin
                    in_valid <= 1'b1;
                    in_data  <= elem_pending_q[0];
                    elem_pending_q.delete(0);
                    in_gap   = pick_gap(in_idle_pct);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        vsu_pkg::t_out_word exp_w;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                words_out++;
                if (dest_expect_q.size() == 0) begin
                    note_mismatch("unexpected output word", '0, out_data.dest_elem);
                end else begin
                    exp_w = dest_expect_q[0];
                    dest_expect_q.delete(0);
                    if (out_data.dest_elem !== exp_w.dest_elem)
                        note_mismatch("dest_elem", exp_w.dest_elem, out_data.dest_elem);
                    if (out_data.last !== exp_w.last)
                        note_mismatch("last", 64'(exp_w.last), 64'(out_data.last));
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                out_stall = pick_gap(out_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words outstanding", $time, dest_expect_q.size());
            $display("vector_slide_unit verification failed");
            $finish;
        end
    end

    task automatic cfg_write(logic [vsu_pkg::CFG_IDX_W-1:0] idx,
                             logic [vsu_pkg::ELEM_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            vsu_pkg::REG_ELEM_WIDTH: cfg_ew     = val[0];
            vsu_pkg::REG_SLIDE_MODE: cfg_mode   = val[1:0];
            vsu_pkg::REG_USE_MASK:   cfg_mask   = val[0];
            vsu_pkg::REG_SLIDE_AMT:  cfg_amt    = val[vsu_pkg::LEN_W-1:0];
            vsu_pkg::REG_VECTOR_LEN: cfg_vlen   = val[vsu_pkg::LEN_W-1:0];
            vsu_pkg::REG_SCALAR:     cfg_scalar = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_slide_setup(logic ew, logic [1:0] mode, logic m,
                                    logic [vsu_pkg::LEN_W-1:0] amt,
                                    logic [vsu_pkg::LEN_W-1:0] vlen,
                                    logic [vsu_pkg::ELEM_W-1:0] scalar);
        cfg_write(vsu_pkg::REG_ELEM_WIDTH, 64'(ew));
        cfg_write(vsu_pkg::REG_SLIDE_MODE, 64'(mode));
        cfg_write(vsu_pkg::REG_USE_MASK, 64'(m));
        if ($urandom_range(3) == 0)
            cfg_write($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, rand_value());
        cfg_write(vsu_pkg::REG_SLIDE_AMT, 64'(amt));
        cfg_write(vsu_pkg::REG_VECTOR_LEN, 64'(vlen));
        cfg_write(vsu_pkg::REG_SCALAR, scalar);
        cfg_we <= 1'b0;
        setups++;
    endtask

    task automatic wait_drained();
        while (elem_pending_q.size() != 0 || in_valid || dest_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int               r;
        int               vl_i;
        int               amt_i;
        int               count;
        logic [1:0]       mode;
        logic             ew;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: 64-bit, slide up by zero, one-element vectors
        queue_word('1, 1'b1, '0);
        queue_word('0, 1'b0, '1);
        wait_drained();

        // slide1 up, 32-bit, masked: scalar at first element despite mask
        load_slide_setup(1'b0, vsu_pkg::MODE_UP1, 1'b1, 9'd1, 9'd4, '1);
        queue_word(64'hDEAD_BEEF_0123_4567, 1'b0, 64'hFFFF_0000_AAAA_5555);
        queue_word(64'h1111_2222_3333_4444, 1'b1, 64'h5555_6666_7777_8888);
        queue_word(64'h9999_AAAA_BBBB_CCCC, 1'b0, 64'hDDDD_EEEE_FFFF_0000);
        queue_word(64'hFEDC_BA98_7654_3210, 1'b1, 64'h0F0F_0F0F_F0F0_F0F0);
        wait_drained();

        // slide down, masked: tail zeroed, inactive keeps old
        load_slide_setup(1'b1, vsu_pkg::MODE_DOWN, 1'b1, 9'd2, 9'd5, rand_value());
        queue_word(rand_value(), 1'b1, rand_value());
        queue_word(rand_value(), 1'b0, rand_value());
        queue_word(rand_value(), 1'b1, rand_value());
        queue_word(rand_value(), 1'b0, rand_value());
        queue_word(rand_value(), 1'b1, rand_value());
        wait_drained();

        // slide1 down: scalar at last element despite mask
        load_slide_setup(1'b1, vsu_pkg::MODE_DOWN1, 1'b1, 9'd1, 9'd3,
                         64'hA5A5_5A5A_C3C3_3C3C);
        queue_word(rand_value(), 1'b1, rand_value());
        queue_word(rand_value(), 1'b0, rand_value());
        queue_word(rand_value(), 1'b0, rand_value());
        wait_drained();

        // slide up: low elements keep old, upper take stored source
        load_slide_setup(1'b1, vsu_pkg::MODE_UP, 1'b0, 9'd3, 9'd6, rand_value());
        queue_rand_words(6);
        wait_drained();

        // slide down by amount past the length: all zero
        load_slide_setup(1'b0, vsu_pkg::MODE_DOWN, 1'b0, 9'd256, 9'd3, rand_value());
        queue_rand_words(3);
        wait_drained();

        for (int p = 0; words_queued < TOTAL_WORDS; p++) begin
            r = $urandom_range(99);
            in_idle_pct  = (r < 25) ? 0 : (r < 50) ? 10 : (r < 80) ? 35 : 70;
            r = $urandom_range(99);
            out_idle_pct = (r < 25) ? 0 : (r < 50) ? 10 : (r < 80) ? 35 : 70;
            ew   = 1'($urandom_range(1));
            mode = 2'($urandom_range(3));
            if (p < 4) begin
                case (p)
                    0: begin vl_i = 256; amt_i = 0;   end
                    1: begin vl_i = 256; amt_i = 256; end
                    2: begin vl_i = 1;   amt_i = 0;   end
                    default: begin vl_i = 256; amt_i = 1; end
                endcase
            end else begin
                r = $urandom_range(99);
                if (r < 60)
                    vl_i = $urandom_range(16, 1);
                else if (r < 85)
                    vl_i = $urandom_range(64, 17);
                else if (r < 95)
                    vl_i = $urandom_range(256, 65);
                else if (r < 97)
                    vl_i = 256;
                else
                    vl_i = $urandom_range(1) ? 0 : $urandom_range(511, 257);
                r = $urandom_range(99);
                if (r < 15)
                    amt_i = 0;
                else if (r < 30)
                    amt_i = 1;
                else if (r < 40)
                    amt_i = vl_i;
                else if (r < 45)
                    amt_i = 256;
                else if (r < 50)
                    amt_i = $urandom_range(511);
                else
                    amt_i = $urandom_range(vl_i + 1 > 511 ? 511 : vl_i + 1);
            end
            load_slide_setup(ew, mode, 1'($urandom_range(1)), 9'(amt_i), 9'(vl_i),
                             rand_value());
            if (vl_i == 0 || vl_i > vsu_pkg::MAX_ELEMENTS_DEF) begin
                count = $urandom_range(300, 20);
            end else begin
                count = vl_i * $urandom_range(64 / vl_i + 1, 1);
                r = $urandom_range(99);
                if (r < 15)
                    count += $urandom_range(5, 1);
                else if (r < 25 && vl_i > 1)
                    count = $urandom_range(vl_i - 1, 1);
            end
            if (count > TOTAL_WORDS - words_queued)
                count = TOTAL_WORDS - words_queued;
            queue_rand_words(count);
            wait_drained();
        end

        if (dest_expect_q.size() != 0)
            note_mismatch("missing output words", 64'(dest_expect_q.size()), '0);
        $display("Checked %0d of %0d words over %0d slide setups, %0d vector ends, %0d narrow",
                 words_out, words_in, setups, vector_ends, narrow_words);
        $display("Words per mode: up %0d, slide1 up %0d, down %0d, slide1 down %0d",
                 mode_words[vsu_pkg::MODE_UP], mode_words[vsu_pkg::MODE_UP1],
                 mode_words[vsu_pkg::MODE_DOWN], mode_words[vsu_pkg::MODE_DOWN1]);
        if (err_cnt == 0) begin
            $display("vector_slide_unit verification clean");
        end else begin
            $display("vector_slide_unit verification failed");
        end
        $finish;
    end

endmodule
